// ----- hw/rtl/gfba_pkg.sv -----
// ----------------------------------------------------------------------------
// gfba_pkg
// shared constants, types and helpers for the grouped free block allocator
// ----------------------------------------------------------------------------
package gfba_pkg;

  localparam int GROUP_SIZE  = 16;
  localparam int BLOCK_COUNT = 1024;

  localparam int SLOTS   = GROUP_SIZE + 1;
  localparam int BLK_W   = 10;
  localparam int FC_W    = 11;
  localparam int GS_W    = $clog2(SLOTS);
  localparam int TOP_W   = GS_W;
  localparam int SLOT_W  = $clog2(SLOTS + 1);
  localparam int CNT_W   = $clog2(SLOTS + 2);
  localparam int CHAIN_W = (BLK_W > TOP_W) ? BLK_W : TOP_W;
  localparam int CA_W    = BLK_W + SLOT_W;
  localparam int CHAIN_DEPTH = BLOCK_COUNT << SLOT_W;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_LINK,
    ST_REFILL,
    ST_SPILL
  } state_t;

  typedef struct packed {
    logic             en;
    logic [GS_W-1:0]  addr;
    logic [BLK_W-1:0] data;
  } gs_wr_t;

  typedef struct packed {
    logic               en;
    logic [CA_W-1:0]    addr;
    logic [CHAIN_W-1:0] data;
  } chain_wr_t;

  function automatic logic blk_in_range(input logic [BLK_W-1:0] blk);
    return {1'b0, blk} < (BLK_W + 1)'(BLOCK_COUNT);
  endfunction

endpackage

// ----- hw/rtl/gfba_group_mem.sv -----
// ----------------------------------------------------------------------------
// gfba_group_mem
// in-core group stack, one write and one registered read port, entries that
// were never written read as zero
// ----------------------------------------------------------------------------
module gfba_group_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gfba_pkg::gs_wr_t              wr,
  input  logic [gfba_pkg::GS_W-1:0]     raddr,
  output logic [gfba_pkg::BLK_W-1:0]    rdata
);

  logic [gfba_pkg::BLK_W-1:0] mem [gfba_pkg::SLOTS];
  logic [gfba_pkg::SLOTS-1:0] valid_r;
  logic [gfba_pkg::BLK_W-1:0] q_r;
  logic                       q_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    q_r <= mem[raddr];
  end

  // valid bits stand in for the all-zero reset of the stack
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      q_vld_r <= valid_r[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule

// ----- hw/rtl/gfba_chain_mem.sv -----
// ----------------------------------------------------------------------------
// gfba_chain_mem
// chain store: one row of slots per block, spilled entries plus saved top
// ----------------------------------------------------------------------------
module gfba_chain_mem (
  input  logic                          clk,
  input  gfba_pkg::chain_wr_t           wr,
  input  logic [gfba_pkg::CA_W-1:0]     raddr,
  output logic [gfba_pkg::CHAIN_W-1:0]  rdata
);

  logic [gfba_pkg::CHAIN_W-1:0] mem [gfba_pkg::CHAIN_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/grouped_free_block_allocator.sv -----
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// classic grouped free list: an in-core group stack backed by a chain store
// ----------------------------------------------------------------------------
// a free that pushes gives its result in the cycle after start; an allocate
//   that pops waits in ST_POP for the group stack read before its result
// group refill and group spill copy one slot a cycle through the single
//   memory ports
// results appear on out_valid for one cycle; the receiver cannot stall
// reset clears the top, the count and the group stack valid bits at once;
//   the chain store is not cleared and no clearing pass is needed
// ----------------------------------------------------------------------------
module grouped_free_block_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [gfba_pkg::BLK_W-1:0]    in_block_number,
  output logic                          out_valid,
  output logic [gfba_pkg::BLK_W-1:0]    out_granted_block,
  output logic                          out_status,
  output logic [gfba_pkg::FC_W-1:0]     out_free_blocks
);

  // control state
  gfba_pkg::state_t              state_r, state_nxt;
  logic [gfba_pkg::TOP_W-1:0]    top_r, top_nxt;
  logic [gfba_pkg::FC_W-1:0]     count_r, count_nxt;
  logic [gfba_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // payload registers
  logic [gfba_pkg::BLK_W-1:0]    blk_r, blk_nxt;
  logic [gfba_pkg::BLK_W-1:0]    link_r, link_nxt;
  logic [gfba_pkg::BLK_W-1:0]    granted_r, granted_nxt;
  logic                          status_r, status_nxt;
  logic [gfba_pkg::FC_W-1:0]     fb_r, fb_nxt;

  // memory ports
  gfba_pkg::gs_wr_t              gs_wr;
  logic [gfba_pkg::GS_W-1:0]     gs_raddr;
  logic [gfba_pkg::BLK_W-1:0]    gs_rdata;
  gfba_pkg::chain_wr_t           ch_wr;
  logic [gfba_pkg::CA_W-1:0]     ch_raddr;
  logic [gfba_pkg::CHAIN_W-1:0]  ch_rdata;

  logic                          accept;
  logic [gfba_pkg::CNT_W-1:0]    idx;       // slot whose read data is back
  logic [gfba_pkg::FC_W-1:0]     count_inc;
  logic [gfba_pkg::FC_W-1:0]     count_dec;

  gfba_group_mem u_group (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (gs_wr),
    .raddr (gs_raddr),
    .rdata (gs_rdata)
  );

  gfba_chain_mem u_chain (
    .clk   (clk),
    .wr    (ch_wr),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  assign busy   = (state_r != gfba_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign idx    = cnt_r - gfba_pkg::CNT_W'(1);

  // saturating count updates
  assign count_inc = (count_r < gfba_pkg::FC_W'(gfba_pkg::BLOCK_COUNT)) ?
                     count_r + gfba_pkg::FC_W'(1) : count_r;
  assign count_dec = (count_r != '0) ? count_r - gfba_pkg::FC_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gfba_pkg::ST_IDLE;
      top_r       <= '0;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r     <= blk_nxt;
    link_r    <= link_nxt;
    granted_r <= granted_nxt;
    status_r  <= status_nxt;
    fb_r      <= fb_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    blk_nxt       = blk_r;
    link_nxt      = link_r;
    out_valid_nxt = 1'b0;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    fb_nxt        = fb_r;
    gs_wr         = '0;
    gs_raddr      = top_r;
    ch_wr         = '0;
    ch_raddr      = {link_r, cnt_r[gfba_pkg::SLOT_W-1:0]};

    unique case (state_r)
      gfba_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == gfba_pkg::OP_FREE) begin
            if (!gfba_pkg::blk_in_range(in_block_number)) begin
              // out of range block: ignored
              out_valid_nxt = 1'b1;
              granted_nxt   = '0;
              status_nxt    = gfba_pkg::STATUS_OK;
              fb_nxt        = count_r;
            end else if (top_r == gfba_pkg::TOP_W'(gfba_pkg::GROUP_SIZE)) begin
              // group full: spill it into the chain row of the freed block
              blk_nxt   = in_block_number;
              cnt_nxt   = '0;
              state_nxt = gfba_pkg::ST_SPILL;
            end else begin
              // plain push
              gs_wr.en      = 1'b1;
              gs_wr.addr    = top_r + gfba_pkg::TOP_W'(1);
              gs_wr.data    = in_block_number;
              top_nxt       = top_r + gfba_pkg::TOP_W'(1);
              count_nxt     = count_inc;
              out_valid_nxt = 1'b1;
              granted_nxt   = '0;
              status_nxt    = gfba_pkg::STATUS_OK;
              fb_nxt        = count_inc;
            end
          end else begin
            // read top entry; at top zero that is the link in entry zero
            gs_raddr  = top_r;
            state_nxt = (top_r == '0) ? gfba_pkg::ST_LINK : gfba_pkg::ST_POP;
          end
        end
      end

      gfba_pkg::ST_POP: begin
        top_nxt       = top_r - gfba_pkg::TOP_W'(1);
        count_nxt     = count_dec;
        out_valid_nxt = 1'b1;
        granted_nxt   = gs_rdata;
        status_nxt    = gfba_pkg::STATUS_OK;
        fb_nxt        = count_dec;
        state_nxt     = gfba_pkg::ST_IDLE;
      end

      gfba_pkg::ST_LINK: begin
        if (gs_rdata == '0 || !gfba_pkg::blk_in_range(gs_rdata)) begin
          // empty list
          out_valid_nxt = 1'b1;
          granted_nxt   = '0;
          status_nxt    = gfba_pkg::STATUS_EMPTY;
          fb_nxt        = count_r;
          state_nxt     = gfba_pkg::ST_IDLE;
        end else begin
          link_nxt  = gs_rdata;
          cnt_nxt   = '0;
          state_nxt = gfba_pkg::ST_REFILL;
        end
      end

      gfba_pkg::ST_REFILL: begin
        // read slot cnt, write back slot cnt-1; last slot holds the top
        ch_raddr = {link_r, cnt_r[gfba_pkg::SLOT_W-1:0]};
        cnt_nxt  = cnt_r + gfba_pkg::CNT_W'(1);
        if (cnt_r != '0) begin
          if (idx < gfba_pkg::CNT_W'(gfba_pkg::SLOTS)) begin
            gs_wr.en   = 1'b1;
            gs_wr.addr = idx[gfba_pkg::GS_W-1:0];
            gs_wr.data = ch_rdata[gfba_pkg::BLK_W-1:0];
          end else begin
            top_nxt = (ch_rdata > gfba_pkg::CHAIN_W'(gfba_pkg::GROUP_SIZE)) ?
                      gfba_pkg::TOP_W'(gfba_pkg::GROUP_SIZE) :
                      ch_rdata[gfba_pkg::TOP_W-1:0];
          end
        end
        if (cnt_r == gfba_pkg::CNT_W'(gfba_pkg::SLOTS + 1)) begin
          count_nxt     = count_dec;
          out_valid_nxt = 1'b1;
          granted_nxt   = link_r;
          status_nxt    = gfba_pkg::STATUS_OK;
          fb_nxt        = count_dec;
          state_nxt     = gfba_pkg::ST_IDLE;
        end
      end

      gfba_pkg::ST_SPILL: begin
        // read group slot cnt, write chain slot cnt-1, then the saved top
        gs_raddr = cnt_r[gfba_pkg::GS_W-1:0];
        cnt_nxt  = cnt_r + gfba_pkg::CNT_W'(1);
        if (cnt_r != '0 && idx < gfba_pkg::CNT_W'(gfba_pkg::SLOTS)) begin
          ch_wr.en   = 1'b1;
          ch_wr.addr = {blk_r, idx[gfba_pkg::SLOT_W-1:0]};
          ch_wr.data = gfba_pkg::CHAIN_W'(gs_rdata);
        end
        if (cnt_r == gfba_pkg::CNT_W'(gfba_pkg::SLOTS + 1)) begin
          ch_wr.en      = 1'b1;
          ch_wr.addr    = {blk_r, gfba_pkg::SLOT_W'(gfba_pkg::SLOTS)};
          ch_wr.data    = gfba_pkg::CHAIN_W'(top_r);
          gs_wr.en      = 1'b1;
          gs_wr.addr    = '0;
          gs_wr.data    = blk_r;
          top_nxt       = '0;
          count_nxt     = count_inc;
          out_valid_nxt = 1'b1;
          granted_nxt   = '0;
          status_nxt    = gfba_pkg::STATUS_OK;
          fb_nxt        = count_inc;
          state_nxt     = gfba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gfba_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = granted_r;
  assign out_status        = status_r;
  assign out_free_blocks   = fb_r;

endmodule

// ----- test/tb_grouped_free_block_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_grouped_free_block_allocator
// self-checking bench for the grouped free block allocator: a behavioural
// copy of the group stack and chain store predicts every response, which is
// compared field by field with what the block returns
// ----------------------------------------------------------------------------
module tb_grouped_free_block_allocator;
  import gfba_pkg::*;

  // slowest path is a refill, allow a couple of them before calling it quiet
  localparam int SETTLE_CYCLES = 2 * (GROUP_SIZE + 5) + 8;
  localparam int ITEMS_PER_PHASE = 80;

  typedef logic [BLK_W-1:0] blk_t;

  // one response as the block should give it
  typedef struct {
    blk_t            granted;
    logic            status;
    logic [FC_W-1:0] free_blocks;
  } grant_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic            in_operation;
  blk_t            in_block_number;
  logic            out_valid;
  blk_t            out_granted_block;
  logic            out_status;
  logic [FC_W-1:0] out_free_blocks;

  // behavioural state of the free list
  blk_t            grp_slots [SLOTS];
  logic [4:0]      grp_top;
  logic [FC_W-1:0] free_cnt;
  blk_t            chain_slots [BLOCK_COUNT * SLOTS];
  logic [4:0]      chain_depth [BLOCK_COUNT];

  grant_t pending_grants [$];
  int     fail_count = 0;
  int     idle_pct = 0;

  grouped_free_block_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_granted_block (out_granted_block),
    .out_status        (out_status),
    .out_free_blocks   (out_free_blocks)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one request to the behavioural free list and return its response
  function automatic grant_t predict_grant(input logic op, input blk_t blk);
    grant_t r;
    blk_t   link;
    r.granted = '0;
    r.status  = STATUS_OK;
    if (grp_top > 5'(GROUP_SIZE)) grp_top = 5'(GROUP_SIZE);
    if (op == OP_ALLOC) begin
      if (grp_top == 0) begin
        link = grp_slots[0];
        if (link == 0 || int'(link) >= BLOCK_COUNT) begin
          // nothing left: state untouched
          r.status = STATUS_EMPTY;
        end else begin
          // hand out the link block and pull its group back in
          r.granted = link;
          if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
          for (int i = 0; i < SLOTS; i++) grp_slots[i] = chain_slots[int'(link) * SLOTS + i];
          grp_top = chain_depth[link];
          if (grp_top > 5'(GROUP_SIZE)) grp_top = 5'(GROUP_SIZE);
        end
      end else begin
        r.granted = grp_slots[grp_top];
        grp_top   = grp_top - 1'b1;
        if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
      end
    end else if (int'(blk) < BLOCK_COUNT) begin
      if (grp_top == 5'(GROUP_SIZE)) begin
        // group full: park it in the freed block, which becomes the new link
        for (int i = 0; i < SLOTS; i++) chain_slots[int'(blk) * SLOTS + i] = grp_slots[i];
        chain_depth[blk] = grp_top;
        grp_slots[0]     = blk;
        grp_top          = '0;
      end else begin
        grp_top            = grp_top + 1'b1;
        grp_slots[grp_top] = blk;
      end
      if (free_cnt < FC_W'(BLOCK_COUNT)) free_cnt = free_cnt + 1'b1;
    end
    r.free_blocks = free_cnt;
    return r;
  endfunction

  // present one item, with a random idle gap ahead of it, and hold it until taken
  task automatic send_request(input logic op, input blk_t blk);
    bit taken;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    in_operation    <= op;
    in_block_number <= blk;
    do begin
      // busy only moves on the clock, so mid-cycle tells what the next edge sees
      @(negedge clk);
      taken = !busy;
      if (taken) pending_grants.push_back(predict_grant(op, blk));
      @(posedge clk);
    end while (!taken);
  endtask

  // stop sending and hold off until every outstanding response is back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  task automatic send_random_free();
    send_request(OP_FREE, blk_t'($urandom_range(BLOCK_COUNT - 1)));
  endtask

  // empty list, block 0, extremes, a spill with a double free, then the refill
  task automatic test_directed();
    idle_pct = 0;
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '1);
    for (int i = 1; i < GROUP_SIZE; i++) send_request(OP_FREE, blk_t'(i * 67));
    // group is now full, so this free spills it
    send_request(OP_FREE, 10'h2aa);
    send_request(OP_FREE, 10'h155);
    send_request(OP_FREE, 10'h155);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, 10'h155);
    send_request(OP_ALLOC, '0);
    wait_drained();
  endtask

  // drive the count into its upper limit, then allocate a few from there
  task automatic test_count_limits();
    idle_pct = 17;
    repeat (BLOCK_COUNT + 20) send_random_free();
    repeat (3) send_request(OP_ALLOC, blk_t'($urandom));
    wait_drained();
  endtask

  // bursts with a changing free/allocate mix so the list grows deep and runs dry
  task automatic test_random_traffic();
    int sent;
    int bias;
    int burst;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       idle_pct = 0;
        1:       idle_pct = 47;
        default: idle_pct = 17;
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        case ($urandom_range(3))
          0:       bias = 25;
          1:       bias = 50;
          2:       bias = 70;
          default: bias = 100;
        endcase
        burst = $urandom_range(10, 60);
        repeat (burst) begin
          if (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < bias) send_random_free();
            else send_request(OP_ALLOC, blk_t'($urandom));
            sent++;
          end
        end
      end
      wait_drained();
    end
  endtask

  // every strobed response is checked against the oldest prediction
  always @(negedge clk) begin : response_check
    grant_t want;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected response: granted_block %0d status %0d free_blocks %0d",
               out_granted_block, out_status, out_free_blocks);
        fail_count++;
      end else begin
        want = pending_grants.pop_front();
        if (out_granted_block !== want.granted) begin
          $error("granted_block: expected %0d, got %0d", want.granted, out_granted_block);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_free_blocks !== want.free_blocks) begin
          $error("free_blocks: expected %0d, got %0d", want.free_blocks, out_free_blocks);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_operation    <= OP_ALLOC;
    in_block_number <= '0;
    foreach (grp_slots[i]) grp_slots[i] = '0;
    foreach (chain_slots[i]) chain_slots[i] = '0;
    foreach (chain_depth[i]) chain_depth[i] = '0;
    grp_top  = '0;
    free_cnt = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic();
    test_count_limits();

    // all responses are in, watch a little longer for anything stray
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/gfba_pkg.sv
hw/rtl/gfba_group_mem.sv
hw/rtl/gfba_chain_mem.sv
hw/rtl/grouped_free_block_allocator.sv
test/tb_grouped_free_block_allocator.sv
